// ===== rtl/sqnlp_pkg.sv =====
package sqnlp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 48;
    localparam int COEFF_W  = 16;
    localparam int SQ_W     = 31;
    localparam int TAP_W    = 18;
    localparam int PROD_W   = DATA_W + TAP_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int ROM_TAPS = 48;

    localparam logic [COEFF_W-1:0] NOTCH_COEFF_RST = 16'd62259;

    localparam logic signed [ACC_W-1:0] SAT_HI = 67'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = -67'sh0_8000_0000_0000;

    // symmetric 600 Hz low-pass taps, signed Q0.17
    localparam logic signed [TAP_W-1:0] LP_TAPS [0:ROM_TAPS-1] = '{
        -18'sd142,   -18'sd144,   -18'sd122,   -18'sd55,
         18'sd72,     18'sd263,    18'sd486,    18'sd674,
         18'sd733,    18'sd564,    18'sd105,   -18'sd632,
        -18'sd1534,  -18'sd2385,  -18'sd2892,  -18'sd2742,
        -18'sd1679,   18'sd422,    18'sd3498,   18'sd7277,
         18'sd11312,  18'sd15047,  18'sd17923,  18'sd19487,
         18'sd19487,  18'sd17923,  18'sd15047,  18'sd11312,
         18'sd7277,   18'sd3498,   18'sd422,   -18'sd1679,
        -18'sd2742,  -18'sd2892,  -18'sd2385,  -18'sd1534,
        -18'sd632,    18'sd105,    18'sd564,    18'sd733,
         18'sd674,    18'sd486,    18'sd263,    18'sd72,
        -18'sd55,    -18'sd122,   -18'sd144,   -18'sd142
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_FEEDBACK,
        ST_NOTCH,
        ST_WRITE,
        ST_TAPS,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    typedef enum logic [1:0] {
        MUL_SQUARE,
        MUL_FEEDBACK,
        MUL_TAP
    } t_mul_sel;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_clr;
        logic     acc_en;
        logic     x_load;
        logic     notch_upd;
        logic     mem_we;
        logic     mem_re;
        logic     out_load;
    } t_ctrl;

    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v > SAT_HI) begin
                r = SAT_HI[DATA_W-1:0];
            end else if (v < SAT_LO) begin
                r = SAT_LO[DATA_W-1:0];
            end else begin
                r = v[DATA_W-1:0];
            end
            return r;
        end
    endfunction

    // taps past the end of the table read as zero
    function automatic logic signed [TAP_W-1:0] tap_coeff(input logic [7:0] idx);
        logic signed [TAP_W-1:0] c;
        begin
            c = '0;
            if (idx < 8'(ROM_TAPS)) begin
                c = LP_TAPS[idx[5:0]];
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/sqnlp_ifs.sv =====
interface sqnlp_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sqnlp_pkg::SAMPLE_W-1:0] speech_sample;

    modport source (output valid, output speech_sample, input ready);
    modport sink   (input valid, input speech_sample, output ready);
endinterface

interface sqnlp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sqnlp_pkg::DATA_W-1:0] filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface

// ===== rtl/sqnlp_dly_ram.sv =====
module sqnlp_dly_ram #(
    parameter int DEPTH = 48,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sqnlp_mac.sv =====
module sqnlp_mac (
    input  logic                                 i_clk,
    input  sqnlp_pkg::t_ctrl                     i_ctrl,
    input  logic signed [sqnlp_pkg::DATA_W-1:0]  i_a,
    input  logic signed [sqnlp_pkg::TAP_W-1:0]   i_b,
    output logic signed [sqnlp_pkg::PROD_W-1:0]  o_prod,
    output logic signed [sqnlp_pkg::ACC_W-1:0]   o_acc
);

    logic signed [sqnlp_pkg::PROD_W-1:0] r_prod;
    logic signed [sqnlp_pkg::PROD_W-1:0] n_prod;
    logic signed [sqnlp_pkg::ACC_W-1:0]  r_acc;

    assign n_prod = i_a * i_b;

    // product register splits the multiplier from the accumulator add
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + {r_prod[sqnlp_pkg::PROD_W-1], r_prod};
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/sqnlp_seq.sv =====
module sqnlp_seq #(
    parameter int TAP_COUNT = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_out_busy,
    output logic                                o_in_ready,
    output sqnlp_pkg::t_ctrl                    o_ctrl,
    output logic [$clog2(TAP_COUNT)-1:0]        o_wr_addr,
    output logic [$clog2(TAP_COUNT)-1:0]        o_rd_addr,
    output logic signed [sqnlp_pkg::TAP_W-1:0]  o_tap,
    output logic                                o_tap_live
);

    localparam int AW = $clog2(TAP_COUNT);
    localparam int CW = $clog2(TAP_COUNT + 1);

    sqnlp_pkg::t_state r_state;
    sqnlp_pkg::t_state n_state;

    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW-1:0] r_tap_idx;
    logic [CW-1:0] r_fill;
    logic          r_p1;
    logic          r_p2;
    logic          r_tap_live;
    logic signed [sqnlp_pkg::TAP_W-1:0] r_tap;

    logic [AW-1:0] wptr_inc;
    logic [AW-1:0] rptr_inc;
    logic          last_tap;
    logic          tap_live;

    assign wptr_inc = (r_wptr == AW'(TAP_COUNT - 1)) ? '0 : r_wptr + AW'(1);
    assign rptr_inc = (r_rptr == AW'(TAP_COUNT - 1)) ? '0 : r_rptr + AW'(1);
    assign last_tap = (r_tap_idx == AW'(TAP_COUNT - 1));
    // a tap holds a real sample once enough samples have been written
    assign tap_live = ({1'b0, CW'(r_tap_idx)} + {1'b0, r_fill}) >= (CW + 1)'(TAP_COUNT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqnlp_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sqnlp_pkg::ST_SQUARE;
            end
            sqnlp_pkg::ST_SQUARE:   n_state = sqnlp_pkg::ST_FEEDBACK;
            sqnlp_pkg::ST_FEEDBACK: n_state = sqnlp_pkg::ST_NOTCH;
            sqnlp_pkg::ST_NOTCH:    n_state = sqnlp_pkg::ST_WRITE;
            sqnlp_pkg::ST_WRITE:    n_state = sqnlp_pkg::ST_TAPS;
            sqnlp_pkg::ST_TAPS: begin
                if (last_tap) n_state = sqnlp_pkg::ST_DRAIN;
            end
            sqnlp_pkg::ST_DRAIN: begin
                if (!r_p1) n_state = sqnlp_pkg::ST_ROUND;
            end
            sqnlp_pkg::ST_ROUND: begin
                if (!i_out_busy) n_state = sqnlp_pkg::ST_IDLE;
            end
            default: n_state = sqnlp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.mul_sel = sqnlp_pkg::MUL_TAP;
        o_ctrl.mul_en  = r_p1;
        o_ctrl.acc_en  = r_p2;
        o_in_ready     = 1'b0;
        unique case (r_state)
            sqnlp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            sqnlp_pkg::ST_SQUARE: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = sqnlp_pkg::MUL_SQUARE;
            end
            sqnlp_pkg::ST_FEEDBACK: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = sqnlp_pkg::MUL_FEEDBACK;
                o_ctrl.x_load  = 1'b1;
            end
            sqnlp_pkg::ST_NOTCH: begin
                o_ctrl.notch_upd = 1'b1;
            end
            sqnlp_pkg::ST_WRITE: begin
                o_ctrl.mem_we  = 1'b1;
                o_ctrl.acc_clr = 1'b1;
            end
            sqnlp_pkg::ST_TAPS: begin
                o_ctrl.mem_re = 1'b1;
            end
            sqnlp_pkg::ST_DRAIN: begin
            end
            sqnlp_pkg::ST_ROUND: begin
                o_ctrl.out_load = !i_out_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sqnlp_pkg::ST_IDLE;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_tap_idx  <= '0;
            r_fill     <= '0;
            r_p1       <= 1'b0;
            r_p2       <= 1'b0;
            r_tap_live <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= o_ctrl.mem_re;
            r_p2    <= r_p1;
            if (o_ctrl.mem_we) begin
                r_wptr    <= wptr_inc;
                r_rptr    <= wptr_inc;
                r_tap_idx <= '0;
                if (r_fill != CW'(TAP_COUNT)) begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (o_ctrl.mem_re) begin
                r_rptr     <= rptr_inc;
                r_tap_idx  <= r_tap_idx + AW'(1);
                r_tap_live <= tap_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ctrl.mem_re) begin
            r_tap <= sqnlp_pkg::tap_coeff(8'(r_tap_idx));
        end
    end

    assign o_wr_addr  = r_wptr;
    assign o_rd_addr  = r_rptr;
    assign o_tap      = r_tap;
    assign o_tap_live = r_tap_live;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.mem_we && o_ctrl.mem_re))
        else $error("delay line written and read in the same cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TAP_COUNT))
        else $error("fill count past tap count");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.acc_en |-> $past(o_ctrl.mul_en))
        else $error("accumulate without a product");

    a_taps_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sqnlp_pkg::ST_TAPS && $past(r_state) == sqnlp_pkg::ST_WRITE)
        |-> (r_tap_idx == '0 && r_rptr == r_wptr))
        else $error("tap walk does not start at the oldest entry");

endmodule

// ===== rtl/square_notch_lowpass_prefilter.sv =====
// Channel   Dir   Payload                          Width  Handshake
// i_in      in    speech_sample (signed)           16     valid/ready
// o_out     out   filtered_value (signed, Q.8)     48     valid/ready
// i_cfg_*   in    notch_coeff (unsigned Q0.16)     16     write enable only
//
// The shared 48x18 multiplier squares each word, forms the notch feedback and
// then walks one tap per cycle; a new word is accepted only once the previous
// result has been loaded into the output register.
// i_in.ready is high only while the sequencer is idle; a result waits in the
// output register, so the next word can be accepted before the result is taken.
// If the output register is still full when the next result is ready, hold it
// in the round state until o_out.ready frees the register.
// Reset (synchronous, active low) clears notch state, fill count and pointers;
// the delay line memory is not cleared, unfilled entries read as zero.
module square_notch_lowpass_prefilter #(
    parameter int TAP_COUNT = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sqnlp_in_if.sink                          i_in,
    sqnlp_out_if.source                       o_out,
    input  logic                              i_cfg_wr_en,
    input  logic [sqnlp_pkg::COEFF_W-1:0]     i_cfg_wr_data
);

    localparam int AW = $clog2(TAP_COUNT);

    sqnlp_pkg::t_ctrl ctrl;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          tap_live;
    logic          in_ready;
    logic          out_busy;

    logic signed [sqnlp_pkg::TAP_W-1:0]   tap;
    logic        [sqnlp_pkg::DATA_W-1:0]  rd_data;
    logic signed [sqnlp_pkg::DATA_W-1:0]  mul_a;
    logic signed [sqnlp_pkg::TAP_W-1:0]   mul_b;
    logic signed [sqnlp_pkg::PROD_W-1:0]  prod;
    logic signed [sqnlp_pkg::ACC_W-1:0]   acc;

    logic [sqnlp_pkg::COEFF_W-1:0]        r_coeff;
    logic signed [sqnlp_pkg::SAMPLE_W-1:0] r_sample;
    logic [sqnlp_pkg::SQ_W-1:0]           r_x;
    logic [sqnlp_pkg::SQ_W-1:0]           r_prev_in;
    logic signed [sqnlp_pkg::DATA_W-1:0]  r_prev_out;
    logic signed [sqnlp_pkg::DATA_W-1:0]  r_out_data;
    logic                                 r_out_valid;

    logic signed [sqnlp_pkg::PROD_W-1:0]  fb_sum;
    logic signed [49:0]                   fb;
    logic signed [31:0]                   diff;
    logic signed [sqnlp_pkg::ACC_W-1:0]   y_wide;
    logic signed [sqnlp_pkg::DATA_W-1:0]  y;
    logic signed [sqnlp_pkg::ACC_W-1:0]   fir_in_wide;
    logic signed [sqnlp_pkg::DATA_W-1:0]  fir_in;
    logic signed [sqnlp_pkg::ACC_W-1:0]   rnd;
    logic signed [sqnlp_pkg::DATA_W-1:0]  result;

    assign out_busy = r_out_valid && !o_out.ready;

    sqnlp_seq #(
        .TAP_COUNT (TAP_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_busy (out_busy),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_tap      (tap),
        .o_tap_live (tap_live)
    );

    sqnlp_dly_ram #(
        .DEPTH (TAP_COUNT),
        .WIDTH (sqnlp_pkg::DATA_W)
    ) u_dly (
        .i_clk   (i_clk),
        .i_we    (ctrl.mem_we),
        .i_waddr (wr_addr),
        .i_wdata (fir_in),
        .i_re    (ctrl.mem_re),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // steer the one multiplier: square, then notch feedback, then the tap walk
    always_comb begin
        case (ctrl.mul_sel)
            sqnlp_pkg::MUL_SQUARE: begin
                mul_a = {{(sqnlp_pkg::DATA_W - sqnlp_pkg::SAMPLE_W){r_sample[15]}}, r_sample};
                mul_b = {{(sqnlp_pkg::TAP_W - sqnlp_pkg::SAMPLE_W){r_sample[15]}}, r_sample};
            end
            sqnlp_pkg::MUL_FEEDBACK: begin
                mul_a = r_prev_out;
                mul_b = {2'b00, r_coeff};
            end
            sqnlp_pkg::MUL_TAP: begin
                // drop entries not yet written since reset
                mul_a = tap_live ? rd_data : '0;
                mul_b = tap;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sqnlp_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod),
        .o_acc  (acc)
    );

    // notch: y = 256*(x - x_prev) + round(coeff * y_prev / 2^16)
    assign fb_sum = prod + 66'sd32768;
    assign fb     = fb_sum[sqnlp_pkg::PROD_W-1:16];
    assign diff   = {1'b0, r_x} - {1'b0, r_prev_in};
    assign y_wide = {{27{diff[31]}}, diff, 8'b0} + {{17{fb[49]}}, fb};
    assign y      = sqnlp_pkg::sat48(y_wide);

    // filter input is notch output plus one in Q.8
    assign fir_in_wide = {{19{r_prev_out[47]}}, r_prev_out} + 67'sd256;
    assign fir_in      = sqnlp_pkg::sat48(fir_in_wide);

    // round the Q.25 sum back to Q.8
    assign rnd    = acc + 67'sd65536;
    assign result = sqnlp_pkg::sat48({{17{rnd[66]}}, rnd[66:17]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= sqnlp_pkg::NOTCH_COEFF_RST;
        end else if (i_cfg_wr_en) begin
            r_coeff <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_sample <= i_in.speech_sample;
        end
        if (ctrl.x_load) begin
            r_x <= prod[sqnlp_pkg::SQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_in  <= '0;
            r_prev_out <= '0;
        end else if (ctrl.notch_upd) begin
            r_prev_in  <= r_x;
            r_prev_out <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_data <= result;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_value = r_out_data;

endmodule

// ===== tb/square_notch_lowpass_prefilter_test.sv =====
`timescale 1ns / 100ps

module square_notch_lowpass_prefilter_test;

    localparam int CLK_HALF_NS = 6;
    // About 10x the slowest expected run (1474 words)
    localparam int RUN_LIMIT_NS = 12 * 1_000_000;
    localparam int IDLE_PCT = 29;
    localparam int FIR_TAPS = 48;
    localparam int SETTLE_CYCLES = FIR_TAPS + 12;

    localparam logic [sqnlp_pkg::COEFF_W-1:0] COEFF_AFTER_RESET = 16'd62259;
    localparam logic [sqnlp_pkg::COEFF_W-1:0] COEFF_MAX = 16'hFFFF;
    localparam logic [sqnlp_pkg::COEFF_W-1:0] COEFF_MIN = 16'h0000;

    localparam logic signed [95:0] Q8_TOP = (96'sd1 <<< 47) - 96'sd1;
    localparam logic signed [95:0] Q8_BOT = -(96'sd1 <<< 47);

    // 600 Hz low-pass, signed Q0.17, symmetric
    localparam int LOWPASS_TAPS [0:FIR_TAPS-1] = '{
        -142, -144, -122, -55, 72, 263, 486, 674,
        733, 564, 105, -632, -1534, -2385, -2892, -2742,
        -1679, 422, 3498, 7277, 11312, 15047, 17923, 19487,
        19487, 17923, 15047, 11312, 7277, 3498, 422, -1679,
        -2742, -2892, -2385, -1534, -632, 105, 564, 733,
        674, 486, 263, 72, -55, -122, -144, -142
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_wr_en;
    logic [sqnlp_pkg::COEFF_W-1:0]   cfg_wr_data;

    sqnlp_in_if  in_if ();
    sqnlp_out_if out_if ();

    square_notch_lowpass_prefilter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Shadow of the block: notch coefficient, notch history and FIR delay line
    logic [sqnlp_pkg::COEFF_W-1:0]         coeff_shadow;
    logic [sqnlp_pkg::SQ_W-1:0]            prev_square;
    logic signed [sqnlp_pkg::DATA_W-1:0]   prev_notch;
    logic signed [sqnlp_pkg::DATA_W-1:0]   fir_history [0:FIR_TAPS-1];

    // Filtered values still owed by the block, oldest first
    logic signed [sqnlp_pkg::DATA_W-1:0]   expected_filtered [$];

    logic                                  src_gaps_on;
    logic                                  sink_stalls_on;
    logic signed [sqnlp_pkg::SAMPLE_W-1:0] last_sample;
    int                                    fail_count;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Saturate a wide Q.8 value to the 48-bit signed range
    function automatic logic signed [sqnlp_pkg::DATA_W-1:0] clamp_q8(
        input logic signed [95:0] v);
        if (v > Q8_TOP) begin
            return Q8_TOP[sqnlp_pkg::DATA_W-1:0];
        end
        if (v < Q8_BOT) begin
            return Q8_BOT[sqnlp_pkg::DATA_W-1:0];
        end
        return v[sqnlp_pkg::DATA_W-1:0];
    endfunction

    task automatic clear_filter_state();
        coeff_shadow = COEFF_AFTER_RESET;
        prev_square  = '0;
        prev_notch   = '0;
        for (int j = 0; j < FIR_TAPS; j++) begin
            fir_history[j] = '0;
        end
    endtask

    // Square, notch, add one, shift into the delay line and run the FIR
    task automatic advance_prefilter(input logic signed [sqnlp_pkg::SAMPLE_W-1:0] s,
                                     output logic signed [sqnlp_pkg::DATA_W-1:0] filtered);
        logic signed [95:0] square;
        logic signed [95:0] old_square;
        logic signed [95:0] feedback;
        logic signed [95:0] wide;
        logic signed [95:0] acc;
        logic signed [sqnlp_pkg::DATA_W-1:0] notch_out;
        square = s;
        square = square * square;
        old_square = prev_square;
        // coeff * y_prev, rounded to 8 fractional bits (floor after +2^15)
        feedback = $signed({1'b0, coeff_shadow}) * prev_notch;
        feedback = (feedback + 96'sd32768) >>> 16;
        notch_out = clamp_q8((square - old_square) * 96'sd256 + feedback);
        prev_square = square[sqnlp_pkg::SQ_W-1:0];
        prev_notch = notch_out;
        // Advance the delay line; newest entry sits at the top
        for (int j = 0; j < FIR_TAPS - 1; j++) begin
            fir_history[j] = fir_history[j + 1];
        end
        wide = notch_out;
        fir_history[FIR_TAPS-1] = clamp_q8(wide + 96'sd256);
        acc = '0;
        for (int j = 0; j < FIR_TAPS; j++) begin
            acc = acc + fir_history[j] * LOWPASS_TAPS[j];
        end
        // Drop the 17 tap fraction bits with round-half-up
        filtered = clamp_q8((acc + 96'sd65536) >>> 17);
    endtask

    // Offer one word, hold it until accepted, then record what it must produce
    task automatic send_sample(input logic signed [sqnlp_pkg::SAMPLE_W-1:0] s);
        logic signed [sqnlp_pkg::DATA_W-1:0] predicted;
        @(negedge i_clk);
        while (src_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.speech_sample <= s;
        do @(posedge i_clk); while (!in_if.ready);
        advance_prefilter(s, predicted);
        expected_filtered.push_back(predicted);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic drain_results(input int extra_cycles);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_filtered.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    // Write the coefficient only while the block is idle
    task automatic set_notch_coeff(input logic [sqnlp_pkg::COEFF_W-1:0] value);
        drain_results(4);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        coeff_shadow = value;
    endtask

    // Mix of full-range noise, quiet speech, rail hits, steady runs and single bits
    function automatic logic signed [sqnlp_pkg::SAMPLE_W-1:0] pick_sample();
        int roll;
        logic signed [sqnlp_pkg::SAMPLE_W-1:0] s;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            s = 16'($urandom);
        end else if (roll < 65) begin
            s = $signed(16'($urandom_range(0, 127))) - 16'sd64;
        end else if (roll < 75) begin
            s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else if (roll < 90) begin
            s = last_sample;
        end else begin
            s = 16'sd1 <<< $urandom_range(0, 15);
            if ($urandom_range(0, 1)) begin
                s = ~s;
            end
        end
        last_sample = s;
        return s;
    endfunction

    task automatic run_random_samples(input int count);
        for (int n = 0; n < count; n++) begin
            send_sample(pick_sample());
        end
    endtask

    // Rails, zero, unit steps and alternating bit patterns at the reset coefficient
    task automatic test_sample_extremes();
        logic signed [sqnlp_pkg::SAMPLE_W-1:0] pattern [0:13];
        pattern = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, 16'sh8000,
                    16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh5555, 16'shAAAA,
                    16'sd256, -16'sd256, 16'sh0000};
        for (int n = 0; n < 14; n++) begin
            send_sample(pattern[n]);
        end
    endtask

    // Feedback near unity with a steady loud input: the notch state lingers
    task automatic test_notch_near_unity();
        set_notch_coeff(COEFF_MAX);
        for (int n = 0; n < 6; n++) begin
            send_sample(16'sh7FFF);
        end
        for (int n = 0; n < 4; n++) begin
            send_sample(16'sh8000);
        end
    endtask

    task automatic test_random_default_coeff();
        set_notch_coeff(COEFF_AFTER_RESET);
        run_random_samples(300);
    endtask

    task automatic test_random_notch_off();
        set_notch_coeff(COEFF_MIN);
        run_random_samples(250);
    endtask

    task automatic test_random_notch_max();
        set_notch_coeff(COEFF_MAX);
        run_random_samples(250);
    endtask

    task automatic test_random_coeff_values();
        for (int k = 0; k < 5; k++) begin
            set_notch_coeff(16'($urandom_range(0, 65535)));
            run_random_samples(50);
        end
    endtask

    // Long stretch with neither side idling
    task automatic test_back_to_back();
        set_notch_coeff(16'h8000);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        run_random_samples(200);
        drain_results(0);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic test_random_min_feedback();
        set_notch_coeff(16'h0001);
        run_random_samples(200);
    endtask

    // Stall the result side at random
    always @(negedge i_clk) begin
        out_if.ready <= sink_stalls_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Compare every taken result against the oldest owed value
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_filtered.size() == 0) begin
                $display("%0t: unexpected filtered_value, expected none, actual %0d",
                         $time, out_if.filtered_value);
                fail_count++;
            end else begin
                if (out_if.filtered_value !== expected_filtered[0]) begin
                    $display("%0t: filtered_value mismatch, expected %0d, actual %0d",
                             $time, expected_filtered[0], out_if.filtered_value);
                    fail_count++;
                end
                void'(expected_filtered.pop_front());
            end
        end
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        in_if.valid         = 1'b0;
        in_if.speech_sample = '0;
        out_if.ready        = 1'b0;
        src_gaps_on         = 1'b1;
        sink_stalls_on      = 1'b1;
        last_sample         = '0;
        fail_count          = 0;
        clear_filter_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sample_extremes();
        test_notch_near_unity();
        test_random_default_coeff();
        test_random_notch_off();
        test_random_notch_max();
        test_random_coeff_values();
        test_back_to_back();
        test_random_min_feedback();

        drain_results(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sqnlp_pkg.sv
rtl/sqnlp_ifs.sv
rtl/sqnlp_dly_ram.sv
rtl/sqnlp_mac.sv
rtl/sqnlp_seq.sv
rtl/square_notch_lowpass_prefilter.sv
tb/square_notch_lowpass_prefilter_test.sv
